FILE: hdl/dbdc_pkg.sv
// Shared types and constants for the dual-beam direction counter.
package dbdc_pkg;

   localparam int SAMPLE_W = 8;
   localparam int STEP_W   = 8;
   localparam int TOTAL_W  = 32;
   localparam int LANE_W   = 4;
   localparam int EVENT_W  = 2;

   localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 8'd110;
   localparam logic [STEP_W-1:0]   MIN_STEPS       = 8'd3;

   localparam logic [1:0] PH_FREE  = 2'b00;
   localparam logic [1:0] PH_OUTER = 2'b01;
   localparam logic [1:0] PH_BOTH  = 2'b10;
   localparam logic [1:0] PH_INNER = 2'b11;

   localparam logic [EVENT_W-1:0] EV_NONE  = 2'd0;
   localparam logic [EVENT_W-1:0] EV_ENTRY = 2'd1;
   localparam logic [EVENT_W-1:0] EV_EXIT  = 2'd2;

   typedef struct packed {
      logic [1:0]        phase;
      logic [STEP_W-1:0] entry_steps;
      logic [STEP_W-1:0] exit_steps;
   } lane_state_type;

   localparam int LANE_STATE_W = $bits(lane_state_type);

   typedef struct packed {
      lane_state_type     next_state;
      logic [EVENT_W-1:0] evt;
   } step_result_type;

endpackage

FILE: hdl/dbdc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module dbdc_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/dbdc_step.sv
// Per-lane phase transition and step counting for one beam sample pair.
module dbdc_step
   import dbdc_pkg::*;
(
   input  logic [SAMPLE_W-1:0] threshold,
   input  logic [SAMPLE_W-1:0] outer_sample,
   input  logic [SAMPLE_W-1:0] inner_sample,
   input  lane_state_type      cur_state,
   output step_result_type     result
);

   function automatic logic [STEP_W-1:0] sat_inc(input logic [STEP_W-1:0] v);
      return (v == {STEP_W{1'b1}}) ? v : v + STEP_W'(1);
   endfunction

   logic outer_blk;
   logic inner_blk;
   logic none_blk;
   logic both_blk;
   logic outer_only;
   logic inner_only;

   assign outer_blk  = outer_sample < threshold;
   assign inner_blk  = inner_sample < threshold;
   assign none_blk   = !outer_blk && !inner_blk;
   assign both_blk   = outer_blk && inner_blk;
   assign outer_only = outer_blk && !inner_blk;
   assign inner_only = !outer_blk && inner_blk;

   always_comb begin
      result.next_state = cur_state;
      result.evt        = EV_NONE;
      case (cur_state.phase)
         PH_FREE: begin
            result.next_state.entry_steps = '0;
            result.next_state.exit_steps  = '0;
            if (outer_only) begin
               result.next_state.entry_steps = STEP_W'(1);
               result.next_state.phase       = PH_OUTER;
            end else if (inner_only) begin
               result.next_state.exit_steps = STEP_W'(1);
               result.next_state.phase      = PH_INNER;
            end
         end
         PH_OUTER: begin
            if (both_blk) begin
               result.next_state.entry_steps = sat_inc(cur_state.entry_steps);
               result.next_state.phase       = PH_BOTH;
            end else if (none_blk) begin
               if (cur_state.exit_steps >= MIN_STEPS) begin
                  result.evt = EV_EXIT;
               end
               result.next_state.phase = PH_FREE;
            end
         end
         PH_BOTH: begin
            if (inner_only) begin
               result.next_state.entry_steps = sat_inc(cur_state.entry_steps);
               result.next_state.phase       = PH_INNER;
            end else if (outer_only) begin
               result.next_state.exit_steps = sat_inc(cur_state.exit_steps);
               result.next_state.phase      = PH_OUTER;
            end else if (none_blk) begin
               result.next_state.phase = PH_FREE;
            end
         end
         default: begin
            if (none_blk) begin
               if (cur_state.entry_steps >= MIN_STEPS) begin
                  result.evt = EV_ENTRY;
               end
               result.next_state.phase = PH_FREE;
            end else if (both_blk) begin
               result.next_state.exit_steps = sat_inc(cur_state.exit_steps);
               result.next_state.phase      = PH_BOTH;
            end
         end
      endcase
   end

endmodule

FILE: hdl/dual_beam_direction_counter.sv
// A request's response is registered in the lane state stage and then in the response register.
// Throughput: one request per cycle unless stalled; lane state is read from RAM at accept and
//   written back at fire, with a one-deep forward for back-to-back same-lane requests.
// Reset: synchronous active-high reset frees every lane (per-lane valid bits),
//   zeroes both totals and loads the trigger threshold with 110; no clearing pass.
module dual_beam_direction_counter
   import dbdc_pkg::*;
#(
   parameter int LANE_COUNT = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [SAMPLE_W-1:0] csr_wr_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [LANE_W-1:0]   req_lane,
   input  logic [SAMPLE_W-1:0] req_outer_sample,
   input  logic [SAMPLE_W-1:0] req_inner_sample,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [EVENT_W-1:0]  rsp_passage_event,
   output logic [LANE_W-1:0]   rsp_event_lane,
   output logic [TOTAL_W-1:0]  rsp_entered_count,
   output logic [TOTAL_W-1:0]  rsp_left_count
);

   localparam int AW = (LANE_COUNT > 1) ? $clog2(LANE_COUNT) : 1;
   localparam int LW = AW + LANE_W;

   logic [SAMPLE_W-1:0]   threshold_ff, threshold_in;
   logic [LANE_COUNT-1:0] valid_ff, valid_in;

   logic                  s1_valid_ff, s1_valid_in;
   logic [LANE_W-1:0]     s1_lane_ff;
   logic [SAMPLE_W-1:0]   s1_outer_ff;
   logic [SAMPLE_W-1:0]   s1_inner_ff;
   logic                  s1_ok_ff;
   logic                  s1_rvalid_ff;
   logic                  fwd_hit_ff, fwd_hit_in;
   lane_state_type        fwd_state_ff;

   logic [TOTAL_W-1:0]    entered_ff, entered_in;
   logic [TOTAL_W-1:0]    left_ff, left_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [EVENT_W-1:0]    rsp_evt_ff;
   logic [LANE_W-1:0]     rsp_lane_ff;
   logic [TOTAL_W-1:0]    rsp_entered_ff;
   logic [TOTAL_W-1:0]    rsp_left_ff;

   logic                  req_fire;
   logic [LW-1:0]         req_lane_wide;
   logic [AW-1:0]         req_addr;
   logic                  req_ok;
   logic [LW-1:0]         s1_lane_wide;
   logic [AW-1:0]         s1_addr;
   logic                  s1_go;
   logic                  s1_fire;
   logic                  wr_en;
   logic [LANE_STATE_W-1:0] ram_rdata;
   lane_state_type        cur_state;
   step_result_type       step_out;
   logic [EVENT_W-1:0]    s1_evt;

   // request side
   assign req_lane_wide = {{AW{1'b0}}, req_lane};
   assign req_addr      = req_lane_wide[AW-1:0];
   assign req_ok        = req_lane_wide < LW'(LANE_COUNT);
   assign req_stall     = s1_valid_ff && !s1_go;
   assign req_fire      = req_valid && !req_stall;

   // lane state stage
   assign s1_lane_wide = {{AW{1'b0}}, s1_lane_ff};
   assign s1_addr      = s1_lane_wide[AW-1:0];
   assign s1_go        = !rsp_valid_ff || !rsp_stall;
   assign s1_fire      = s1_valid_ff && s1_go;
   assign wr_en        = s1_fire && s1_ok_ff;

   dbdc_ram #(
      .WIDTH(LANE_STATE_W),
      .DEPTH(LANE_COUNT)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_addr),
      .wr_data (step_out.next_state),
      .rd_en   (req_fire),
      .rd_addr (req_addr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      if (fwd_hit_ff) begin
         cur_state = fwd_state_ff;
      end else if (s1_rvalid_ff) begin
         cur_state = lane_state_type'(ram_rdata);
      end else begin
         cur_state = '0;
      end
   end

   dbdc_step u_step (
      .threshold    (threshold_ff),
      .outer_sample (s1_outer_ff),
      .inner_sample (s1_inner_ff),
      .cur_state    (cur_state),
      .result       (step_out)
   );

   assign s1_evt = s1_ok_ff ? step_out.evt : EV_NONE;

   always_comb begin
      threshold_in = csr_wr_en ? csr_wr_data : threshold_ff;
      valid_in     = valid_ff;
      if (wr_en) begin
         valid_in[s1_addr] = 1'b1;
      end
      s1_valid_in  = req_fire || (s1_valid_ff && !s1_go);
      fwd_hit_in   = wr_en && (req_addr == s1_addr);
      entered_in   = entered_ff;
      left_in      = left_ff;
      if (s1_fire && (s1_evt == EV_ENTRY)) begin
         entered_in = entered_ff + TOTAL_W'(1);
      end
      if (s1_fire && (s1_evt == EV_EXIT)) begin
         left_in = left_ff + TOTAL_W'(1);
      end
      rsp_valid_in = s1_fire || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         valid_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_hit_ff   <= 1'b0;
         entered_ff   <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         threshold_ff <= threshold_in;
         valid_ff     <= valid_in;
         s1_valid_ff  <= s1_valid_in;
         entered_ff   <= entered_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            fwd_hit_ff <= fwd_hit_in;
         end
      end
   end

   // hold payload while stalled
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_lane_ff   <= req_lane;
         s1_outer_ff  <= req_outer_sample;
         s1_inner_ff  <= req_inner_sample;
         s1_ok_ff     <= req_ok;
         s1_rvalid_ff <= valid_ff[req_addr];
         fwd_state_ff <= step_out.next_state;
      end
      if (s1_fire) begin
         rsp_evt_ff     <= s1_evt;
         rsp_lane_ff    <= s1_lane_ff;
         rsp_entered_ff <= entered_in;
         rsp_left_ff    <= left_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_passage_event = rsp_evt_ff;
   assign rsp_event_lane    = rsp_lane_ff;
   assign rsp_entered_count = rsp_entered_ff;
   assign rsp_left_count    = rsp_left_ff;

`ifndef ASSERT_OFF
   a_entry_count: assert property (@(posedge clock) disable iff (reset)
      s1_fire && (s1_evt == EV_ENTRY) |=> entered_ff == $past(entered_ff) + TOTAL_W'(1))
      else $error("entered total did not advance on entry");

   a_exit_count: assert property (@(posedge clock) disable iff (reset)
      s1_fire && (s1_evt == EV_EXIT) |=> left_ff == $past(left_ff) + TOTAL_W'(1))
      else $error("left total did not advance on exit");

   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid_ff)
      else $error("request stalled with free pipeline");

   a_lane_valid: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> valid_ff[$past(s1_addr)])
      else $error("lane written but not marked valid");
`endif

endmodule
